[rtl/core/assert_macros.svh]
// assertion macros for the fence fill core
// depends on a clock named clk and an active-low reset named arst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define FPF_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("fence fill assertion failed");

// condition must never be true outside reset
`define FPF_NEVER(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("fence fill forbidden condition seen");

`endif

[rtl/core/fpf_pkg.sv]
// shared types, codes and defaults for the fence fill core
// no dependencies
package fpf_pkg;

	// default sizes, handed to the top level parameters
	localparam int DEF_IMAGE_WIDTH   = 64;
	localparam int DEF_IMAGE_HEIGHT  = 64;
	localparam int DEF_FRACTION_BITS = 16;

	// coordinate and fence widths fixed by the interface
	localparam int COORD_W = 6;
	localparam int FENCE_W = 7;
	localparam int ROW_W   = 64;

	// command queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// input mode codes
	localparam logic [1:0] MODE_CLEAR = 2'd0;
	localparam logic [1:0] MODE_DRAW  = 2'd1;
	localparam logic [1:0] MODE_READ  = 2'd2;

	typedef enum logic [1:0] {
		OP_CLEAR,
		OP_DRAW,
		OP_READ
	} op_t;

	// classified command word; for reads the row travels in ya
	typedef struct packed {
		op_t                op;
		logic [COORD_W-1:0] xa;
		logic [COORD_W-1:0] ya;
		logic [COORD_W-1:0] yb;
		logic               dx_neg;
		logic [COORD_W-1:0] dx_mag;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	typedef enum logic [2:0] {
		BK_INIT,
		BK_IDLE,
		BK_DIV,
		BK_WALK,
		BK_CLEAR,
		BK_READ,
		BK_READ_DATA
	} back_state_t;

endpackage

[rtl/core/fpf_ram.sv]
// generic single write port ram with registered read
// no dependencies
module fpf_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[rtl/core/fpf_front.sv]
// front end: accepts words, orders edge endpoints and filters no-op words
// depends on fpf_pkg
module fpf_front (
	input  logic                     start,
	input  logic [1:0]               mode,
	input  logic [5:0]               x_first,
	input  logic [5:0]               y_first,
	input  logic [5:0]               x_second,
	input  logic [5:0]               y_second,
	input  logic [5:0]               read_row,
	input  fpf_pkg::q_status_t       q_stat,
	input  logic                     init_clear,
	output logic                     busy,
	output logic                     push,
	output fpf_pkg::cmd_t            cmd
);
	import fpf_pkg::*;

	logic               accept;
	logic               keep;
	logic               swap;
	logic [COORD_W-1:0] xa, ya, xb, yb;

	// hold off while the queue is full or the bitmap is being wiped
	assign busy   = q_stat.full | init_clear;
	assign accept = start & ~busy;
	assign push   = accept & keep;

	// order endpoints so the first has the lower y
	assign swap = y_first > y_second;
	assign xa   = swap ? x_second : x_first;
	assign ya   = swap ? y_second : y_first;
	assign xb   = swap ? x_first  : x_second;
	assign yb   = swap ? y_first  : y_second;

	// classify the word
	always_comb begin
		cmd        = '0;
		cmd.op     = OP_CLEAR;
		keep       = 1'b0;
		unique case (mode)
			MODE_CLEAR: begin
				keep   = 1'b1;
			end
			MODE_DRAW: begin
				cmd.op     = OP_DRAW;
				cmd.xa     = xa;
				cmd.ya     = ya;
				cmd.yb     = yb;
				cmd.dx_neg = xb < xa;
				cmd.dx_mag = (xb < xa) ? (xa - xb) : (xb - xa);
				// horizontal edges touch no row
				keep       = ya != yb;
			end
			MODE_READ: begin
				cmd.op = OP_READ;
				cmd.ya = read_row;
				keep   = 1'b1;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

endmodule

[rtl/core/fpf_queue.sv]
// short command queue between front and back
// depends on fpf_pkg
module fpf_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  fpf_pkg::cmd_t      push_cmd,
	input  logic               pop,
	output fpf_pkg::cmd_t      head,
	output fpf_pkg::q_status_t status
);
	import fpf_pkg::*;

	cmd_t              entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign head         = entry_q[rd_ptr_q];
	assign status.full  = cnt_q == QCNT_W'(QUEUE_DEPTH);
	assign status.empty = cnt_q == '0;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

[rtl/core/fpf_back.sv]
// back end: step divider, scanline walker with row read-modify-write,
// clear sweep and row read; depends on fpf_pkg and fpf_ram
module fpf_back #(
	parameter int IMAGE_WIDTH   = fpf_pkg::DEF_IMAGE_WIDTH,
	parameter int IMAGE_HEIGHT  = fpf_pkg::DEF_IMAGE_HEIGHT,
	parameter int FRACTION_BITS = fpf_pkg::DEF_FRACTION_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  fpf_pkg::q_status_t           q_stat,
	input  fpf_pkg::cmd_t                q_head,
	output logic                         q_pop,
	input  logic [fpf_pkg::FENCE_W-1:0]  partition_x,
	output logic                         init_clear,
	output logic                         row_valid,
	output logic [fpf_pkg::ROW_W-1:0]    row_bits
);
	import fpf_pkg::*;

	localparam int AW = $clog2(IMAGE_HEIGHT);
	localparam int DW = COORD_W + FRACTION_BITS;
	localparam int CW = $clog2(DW + 1);

	back_state_t        state_q, state_d;
	cmd_t               cmd_q;
	logic [COORD_W:0]   rem_q;
	logic [DW-1:0]      quo_q;
	logic [CW-1:0]      cnt_q;
	logic [DW-1:0]      step_q;
	logic [DW-1:0]      x_q;
	logic [COORD_W-1:0] scan_q;
	logic [AW-1:0]      clr_q;
	logic               rd_ok_q;
	logic               wr_valid_s1;
	logic [AW-1:0]      wr_addr_s1;
	logic [IMAGE_WIDTH-1:0] mask_s1;
	logic               row_valid_q;
	logic [ROW_W-1:0]   row_bits_q;

	logic [COORD_W-1:0] dy;
	logic [COORD_W:0]   rem_sh;
	logic               fits;
	logic [COORD_W:0]   rem_nx;
	logic [DW-1:0]      quo_nx;
	logic [DW-1:0]      step_nx;
	logic               div_last;
	logic [COORD_W-1:0] col;
	logic               walk_more;
	logic               row_in;
	logic               rd_in;
	logic               clr_last;

	logic                   ram_we;
	logic [AW-1:0]          ram_waddr;
	logic [IMAGE_WIDTH-1:0] ram_wdata;
	logic                   ram_re;
	logic [AW-1:0]          ram_raddr;
	logic [IMAGE_WIDTH-1:0] ram_rdata;

	// toggle span on one row for column c and fence f, clipped to the image
	function automatic logic [IMAGE_WIDTH-1:0] span_mask(
		input logic [COORD_W-1:0] c,
		input logic [FENCE_W-1:0] f
	);
		logic [FENCE_W-1:0] lo;
		logic [FENCE_W-1:0] hi;
		logic [ROW_W-1:0]   m;
		if ({1'b0, c} < f) begin
			lo = {1'b0, c} + FENCE_W'(1);
			hi = f - FENCE_W'(1);
		end else begin
			lo = f;
			hi = {1'b0, c};
		end
		if (hi > FENCE_W'(IMAGE_WIDTH - 1)) begin
			hi = FENCE_W'(IMAGE_WIDTH - 1);
		end
		if (lo > hi) begin
			m = '0;
		end else begin
			m = ({ROW_W{1'b1}} >> (FENCE_W'(ROW_W - 1) - hi)) & ({ROW_W{1'b1}} << lo);
		end
		return m[IMAGE_WIDTH-1:0];
	endfunction

	// restoring divider, one quotient bit per cycle
	assign dy       = cmd_q.yb - cmd_q.ya;
	assign rem_sh   = {rem_q[COORD_W-1:0], quo_q[DW-1]};
	assign fits     = rem_sh >= {1'b0, dy};
	assign rem_nx   = fits ? (rem_sh - {1'b0, dy}) : rem_sh;
	assign quo_nx   = {quo_q[DW-2:0], fits};
	assign step_nx  = cmd_q.dx_neg ? ((~quo_nx) + DW'(1)) : quo_nx;
	assign div_last = cnt_q == CW'(DW - 1);

	// walker row decode
	assign col       = x_q[DW-1 -: COORD_W];
	assign walk_more = scan_q != cmd_q.yb;
	assign row_in    = int'(scan_q) < IMAGE_HEIGHT;
	assign rd_in     = int'(cmd_q.ya) < IMAGE_HEIGHT;
	assign clr_last  = clr_q == AW'(IMAGE_HEIGHT - 1);

	// next state and queue pop
	always_comb begin
		state_d = state_q;
		q_pop   = 1'b0;
		unique case (state_q)
			BK_INIT, BK_CLEAR: begin
				if (clr_last) begin
					state_d = BK_IDLE;
				end
			end
			BK_IDLE: begin
				if (!q_stat.empty) begin
					q_pop = 1'b1;
					case (q_head.op)
						OP_CLEAR: state_d = BK_CLEAR;
						OP_DRAW:  state_d = BK_DIV;
						OP_READ:  state_d = BK_READ;
						default:  state_d = BK_IDLE;
					endcase
				end
			end
			BK_DIV: begin
				if (div_last) begin
					state_d = BK_WALK;
				end
			end
			BK_WALK: begin
				if (!walk_more) begin
					state_d = BK_IDLE;
				end
			end
			BK_READ: begin
				state_d = BK_READ_DATA;
			end
			BK_READ_DATA: begin
				state_d = BK_IDLE;
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	// state and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_INIT;
			clr_q       <= '0;
			cnt_q       <= '0;
			wr_valid_s1 <= 1'b0;
			row_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			row_valid_q <= state_q == BK_READ_DATA;
			wr_valid_s1 <= (state_q == BK_WALK) && walk_more && row_in;
			if ((state_q == BK_INIT) || (state_q == BK_CLEAR)) begin
				clr_q <= clr_q + AW'(1);
			end else begin
				clr_q <= '0;
			end
			if (state_q == BK_DIV) begin
				cnt_q <= cnt_q + CW'(1);
			end else begin
				cnt_q <= '0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q <= q_head;
			rem_q <= '0;
			quo_q <= {q_head.dx_mag, {FRACTION_BITS{1'b0}}};
		end
		if (state_q == BK_DIV) begin
			rem_q <= rem_nx;
			quo_q <= quo_nx;
			if (div_last) begin
				step_q <= step_nx;
				x_q    <= {cmd_q.xa, {FRACTION_BITS{1'b0}}};
				scan_q <= cmd_q.ya;
			end
		end
		if ((state_q == BK_WALK) && walk_more) begin
			x_q        <= x_q + step_q;
			scan_q     <= scan_q + COORD_W'(1);
			wr_addr_s1 <= AW'(scan_q);
			mask_s1    <= span_mask(col, partition_x);
		end
		if (state_q == BK_READ) begin
			rd_ok_q <= rd_in;
		end
		if (state_q == BK_READ_DATA) begin
			row_bits_q <= rd_ok_q ? ROW_W'(ram_rdata) : '0;
		end
	end

	// bitmap port muxing
	always_comb begin
		ram_we    = wr_valid_s1;
		ram_waddr = wr_addr_s1;
		ram_wdata = ram_rdata ^ mask_s1;
		ram_re    = 1'b0;
		ram_raddr = AW'(scan_q);
		if ((state_q == BK_INIT) || (state_q == BK_CLEAR)) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = '0;
		end
		if (state_q == BK_WALK) begin
			ram_re = walk_more && row_in;
		end
		if (state_q == BK_READ) begin
			ram_re    = rd_in;
			ram_raddr = AW'(cmd_q.ya);
		end
	end

	fpf_ram #(
		.WIDTH(IMAGE_WIDTH),
		.DEPTH(IMAGE_HEIGHT)
	) u_bitmap (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign init_clear = state_q == BK_INIT;
	assign row_valid  = row_valid_q;
	assign row_bits   = row_bits_q;

endmodule

[rtl/core/fence_polygon_fill.sv]
// fence fill core top level: config register, front, queue and back
// depends on fpf_pkg, fpf_front, fpf_queue, fpf_back and assert_macros.svh
`include "assert_macros.svh"

// Fence polygon fill on a one-bit bitmap of IMAGE_HEIGHT rows by IMAGE_WIDTH
// columns. Words are taken when start is high and busy is low; the front end
// classifies them and queues up to two, so busy rises only with the queue
// full, and after reset while the bitmap is wiped one row per cycle. In the
// back end a clear also wipes the bitmap row by row; a draw first runs the
// serial step divider, then walks one scanline per cycle, each a
// read-modify-write through the bitmap memory's single write port. A read
// puts the row on row_bits with row_valid high for exactly one cycle; the
// receiver cannot stall it. Write partition_x only while the core is idle.
module fence_polygon_fill #(
	parameter int IMAGE_WIDTH   = fpf_pkg::DEF_IMAGE_WIDTH,
	parameter int IMAGE_HEIGHT  = fpf_pkg::DEF_IMAGE_HEIGHT,
	parameter int FRACTION_BITS = fpf_pkg::DEF_FRACTION_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        partition_we,
	input  logic [fpf_pkg::FENCE_W-1:0] partition_x,
	input  logic                        start,
	output logic                        busy,
	input  logic [1:0]                  mode,
	input  logic [5:0]                  x_first,
	input  logic [5:0]                  y_first,
	input  logic [5:0]                  x_second,
	input  logic [5:0]                  y_second,
	input  logic [5:0]                  read_row,
	output logic                        row_valid,
	output logic [fpf_pkg::ROW_W-1:0]   row_bits
);
	import fpf_pkg::*;

	logic [FENCE_W-1:0] partition_q;
	q_status_t          q_stat;
	logic               q_push;
	logic               q_pop;
	cmd_t               push_cmd;
	cmd_t               q_head;
	logic               init_clear;

	// fence column register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partition_q <= '0;
		end else if (partition_we) begin
			partition_q <= partition_x;
		end
	end

	fpf_front u_front (
		.start     (start),
		.mode      (mode),
		.x_first   (x_first),
		.y_first   (y_first),
		.x_second  (x_second),
		.y_second  (y_second),
		.read_row  (read_row),
		.q_stat    (q_stat),
		.init_clear(init_clear),
		.busy      (busy),
		.push      (q_push),
		.cmd       (push_cmd)
	);

	fpf_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.push_cmd(push_cmd),
		.pop     (q_pop),
		.head    (q_head),
		.status  (q_stat)
	);

	fpf_back #(
		.IMAGE_WIDTH  (IMAGE_WIDTH),
		.IMAGE_HEIGHT (IMAGE_HEIGHT),
		.FRACTION_BITS(FRACTION_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_stat     (q_stat),
		.q_head     (q_head),
		.q_pop      (q_pop),
		.partition_x(partition_q),
		.init_clear (init_clear),
		.row_valid  (row_valid),
		.row_bits   (row_bits)
	);

	// queue never overflows or underflows
	`FPF_NEVER(a_push_when_full, q_push && q_stat.full)
	`FPF_NEVER(a_pop_when_empty, q_pop && q_stat.empty)
	// nothing enters while the bitmap is wiped after reset
	`FPF_NEVER(a_push_during_init, q_push && init_clear)
	// each read gives a single-cycle result
	`FPF_ASSERT(a_result_one_cycle, row_valid |=> !row_valid)

endmodule
